@@ rtl/vacuum_start_interlock_sequencer_core_macros.svh @@
// ----------------------------------------------------------------------------
// vacuum start interlock sequencer assertion macros
// shared property wrappers for the port checker, clocked on clk
// ----------------------------------------------------------------------------
`ifndef VACUUM_START_INTERLOCK_SEQUENCER_CORE_MACROS_SVH
`define VACUUM_START_INTERLOCK_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define VSIS_ASSERT_NOW(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VSIS_ASSERT_NEXT(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vsis_pkg.sv @@
// ----------------------------------------------------------------------------
// vsis_pkg
// types, codes and field layout shared by the sequencer and its checker
// ----------------------------------------------------------------------------
`default_nettype none

package vsis_pkg;

  localparam int TIME_BITS     = 16;
  localparam int PRESSURE_BITS = 40;
  localparam int PX_BITS       = PRESSURE_BITS + 4;  // room for 11 * pressure
  localparam int CONFIRM_BITS  = 8;
  localparam int CMD_BITS      = 2;
  localparam int STATUS_BITS   = 3;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // tdata layout of result words
  localparam int OUT_CMD_LSB    = 0;
  localparam int OUT_STATUS_LSB = OUT_CMD_LSB + CMD_BITS;
  localparam int OUT_EL_LSB     = OUT_STATUS_LSB + STATUS_BITS;
  localparam int OUT_HELD_LSB   = OUT_EL_LSB + TIME_BITS;

  localparam logic [PRESSURE_BITS-1:0] START_PRESSURE_RST = PRESSURE_BITS'(1000);
  localparam logic [TIME_BITS-1:0]     MAX_WAIT_RST       = TIME_BITS'(10);
  localparam logic [TIME_BITS-1:0]     HOLD_RST           = TIME_BITS'(60);
  localparam logic [CONFIRM_BITS-1:0]  CONFIRM_LIMIT_RST  = CONFIRM_BITS'(50);

  typedef enum logic [1:0] {
    REG_START_PRESSURE = 2'd0,
    REG_MAX_WAIT       = 2'd1,
    REG_HOLD           = 2'd2,
    REG_CONFIRM_LIMIT  = 2'd3
  } reg_index_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_NONE         = 2'd0,
    CMD_SET_EXHAUST  = 2'd1,
    CMD_TOGGLE_VALVE = 2'd2
  } command_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_RUN      = 3'd0,
    ST_OK       = 3'd1,
    ST_CANCEL   = 3'd2,
    ST_MODE_ERR = 3'd3,
    ST_VALVE    = 3'd4,
    ST_PRESS    = 3'd5,
    ST_OVERTIME = 3'd6,
    ST_COMM     = 3'd7
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_WAIT  = 5'b00010,
    PH_EXH   = 5'b00100,
    PH_VALVE = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                     operation;
    logic                     comm_ok;
    logic [PRESSURE_BITS-1:0] pressure;
    logic [PX_BITS-1:0]       pressure_x10;
    logic                     valve_open;
    logic                     manual_exhaust;
    logic                     cancel_pressed;
  } item_t;

  typedef struct packed {
    command_t             command;
    status_t              status;
    logic [TIME_BITS-1:0] elapsed_seconds;
    logic [TIME_BITS-1:0] held_seconds;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/vacuum_start_interlock_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// vacuum_start_interlock_sequencer_core
// start supervision of a vacuum test: pressure hold, exhaust and valve sequence
// ----------------------------------------------------------------------------
// Takes one word per clock while results are taken and presents one result
// word per input word: the word lands in an input register, and one pass of
// logic updates the run state and fills the result register once that register
// is empty or being taken. Throughput is one word per cycle under the same
// condition, set by that single state-update pass; a stalled result holds back
// the input side only once the input register is also full.
// Registers are written over the APB port at byte address 8*i and should be
// written only while no word is in flight.
`default_nettype none

module vacuum_start_interlock_sequencer_core (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // stream in
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // comm_ok, pressure[40], valve_open, manual_exhaust, cancel_pressed, pad[4]
  input  wire logic [vsis_pkg::IN_DATA_W-1:0]   s_tdata,
  // operation
  input  wire logic                             s_tuser,
  // stream out
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // command[2], status[3], elapsed_seconds[16], held_seconds[16], pad[3]
  output logic [vsis_pkg::OUT_DATA_W-1:0]       m_tdata,
  // register port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [vsis_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [vsis_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [vsis_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int PB = vsis_pkg::PRESSURE_BITS;
  localparam int PX = vsis_pkg::PX_BITS;
  localparam int TB = vsis_pkg::TIME_BITS;
  localparam int CB = vsis_pkg::CONFIRM_BITS;

  // configuration
  logic [PB-1:0] start_pressure;
  logic [PX-1:0] start_x11;
  logic [TB-1:0] max_wait_seconds;
  logic [TB-1:0] hold_seconds;
  logic [CB-1:0] confirm_poll_limit;

  logic                 cfg_we;
  vsis_pkg::reg_index_t cfg_idx;
  logic [PX-1:0]        wr_ext;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = vsis_pkg::reg_index_t'(paddr[4:3]);
  assign wr_ext  = {4'b0, pwdata[PB-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pressure     <= vsis_pkg::START_PRESSURE_RST;
      start_x11          <= PX'(11) * {4'b0, vsis_pkg::START_PRESSURE_RST};
      max_wait_seconds   <= vsis_pkg::MAX_WAIT_RST;
      hold_seconds       <= vsis_pkg::HOLD_RST;
      confirm_poll_limit <= vsis_pkg::CONFIRM_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        vsis_pkg::REG_START_PRESSURE: begin
          start_pressure <= pwdata[PB-1:0];
          // 11*s kept alongside so the 10% test is one compare
          start_x11      <= (wr_ext << 3) + (wr_ext << 1) + wr_ext;
        end
        vsis_pkg::REG_MAX_WAIT:      max_wait_seconds   <= pwdata[TB-1:0];
        vsis_pkg::REG_HOLD:          hold_seconds       <= pwdata[TB-1:0];
        vsis_pkg::REG_CONFIRM_LIMIT: confirm_poll_limit <= pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      vsis_pkg::REG_START_PRESSURE: prdata = 64'(start_pressure);
      vsis_pkg::REG_MAX_WAIT:       prdata = 64'(max_wait_seconds);
      vsis_pkg::REG_HOLD:           prdata = 64'(hold_seconds);
      vsis_pkg::REG_CONFIRM_LIMIT:  prdata = 64'(confirm_poll_limit);
      default:                      prdata = '0;
    endcase
  end

  // input register
  vsis_pkg::item_t   item;
  vsis_pkg::item_t   item_next;
  logic              item_valid;
  logic              advance;
  logic [PX-1:0]     p_ext;

  assign advance  = item_valid & (~m_tvalid | m_tready);
  assign s_tready = ~item_valid | advance;
  assign p_ext    = {4'b0, s_tdata[PB:1]};

  always_comb begin
    item_next.operation      = s_tuser;
    item_next.comm_ok        = s_tdata[0];
    item_next.pressure       = s_tdata[PB:1];
    item_next.pressure_x10   = (p_ext << 3) + (p_ext << 1);
    item_next.valve_open     = s_tdata[PB+1];
    item_next.manual_exhaust = s_tdata[PB+2];
    item_next.cancel_pressed = s_tdata[PB+3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_next;
    end
  end

  // run state
  vsis_pkg::phase_t  phase, phase_next;
  vsis_pkg::status_t final_status, final_status_next;
  logic [TB-1:0]     elapsed_count, elapsed_count_next;
  logic [TB-1:0]     hold_count, hold_count_next;
  logic [CB-1:0]     confirm_count, confirm_count_next;
  vsis_pkg::command_t cmd;

  logic [CB-1:0] confirm_inc;
  logic [CB-1:0] confirm_lim;
  logic          confirm_out;
  logic [TB:0]   overtime_lim;

  assign confirm_inc  = (confirm_count != '1) ? confirm_count + CB'(1) : confirm_count;
  assign confirm_lim  = (confirm_poll_limit == '0) ? CB'(1) : confirm_poll_limit;
  assign confirm_out  = (confirm_inc >= confirm_lim);
  assign overtime_lim = {1'b0, max_wait_seconds} + {1'b0, hold_seconds};

  always_comb begin
    phase_next         = phase;
    final_status_next  = final_status;
    elapsed_count_next = elapsed_count;
    hold_count_next    = hold_count;
    confirm_count_next = confirm_count;
    cmd                = vsis_pkg::CMD_NONE;
    if (item.operation) begin
      phase_next         = vsis_pkg::PH_WAIT;
      final_status_next  = vsis_pkg::ST_RUN;
      elapsed_count_next = '0;
      hold_count_next    = '0;
      confirm_count_next = '0;
    end else begin
      case (phase)
        vsis_pkg::PH_WAIT: begin
          if (elapsed_count != '1) begin
            elapsed_count_next = elapsed_count + TB'(1);
          end
          if (item.cancel_pressed) begin
            phase_next        = vsis_pkg::PH_DONE;
            final_status_next = vsis_pkg::ST_CANCEL;
          end else if (!item.comm_ok) begin
            phase_next        = vsis_pkg::PH_DONE;
            final_status_next = vsis_pkg::ST_COMM;
          end else if (item.pressure <= start_pressure) begin
            if (!item.valve_open) begin
              phase_next        = vsis_pkg::PH_DONE;
              final_status_next = vsis_pkg::ST_OK;
            end else begin
              if (hold_count != '1) begin
                hold_count_next = hold_count + TB'(1);
              end
              if (hold_count_next >= hold_seconds) begin
                cmd                = vsis_pkg::CMD_SET_EXHAUST;
                confirm_count_next = '0;
                phase_next         = vsis_pkg::PH_EXH;
              end
            end
          end else begin
            if (hold_count != '0) begin
              hold_count_next = hold_count - TB'(1);
            end
            // more than 10% over the start level: 10p > 11s
            if (!item.valve_open && (item.pressure_x10 > start_x11)) begin
              phase_next        = vsis_pkg::PH_DONE;
              final_status_next = vsis_pkg::ST_PRESS;
            end
          end
          if (phase_next == vsis_pkg::PH_WAIT &&
              ({1'b0, elapsed_count_next} >= overtime_lim ||
               (elapsed_count_next >= max_wait_seconds && hold_count_next == '0))) begin
            phase_next        = vsis_pkg::PH_DONE;
            final_status_next = vsis_pkg::ST_OVERTIME;
          end
        end
        vsis_pkg::PH_EXH: begin
          if (item.cancel_pressed) begin
            phase_next        = vsis_pkg::PH_DONE;
            final_status_next = vsis_pkg::ST_CANCEL;
          end else if (!item.comm_ok) begin
            phase_next        = vsis_pkg::PH_DONE;
            final_status_next = vsis_pkg::ST_COMM;
          end else if (item.manual_exhaust) begin
            cmd                = vsis_pkg::CMD_TOGGLE_VALVE;
            confirm_count_next = '0;
            phase_next         = vsis_pkg::PH_VALVE;
          end else begin
            confirm_count_next = confirm_inc;
            if (confirm_out) begin
              phase_next        = vsis_pkg::PH_DONE;
              final_status_next = vsis_pkg::ST_MODE_ERR;
            end
          end
        end
        vsis_pkg::PH_VALVE: begin
          if (item.cancel_pressed) begin
            phase_next        = vsis_pkg::PH_DONE;
            final_status_next = vsis_pkg::ST_CANCEL;
          end else if (!item.comm_ok) begin
            phase_next        = vsis_pkg::PH_DONE;
            final_status_next = vsis_pkg::ST_COMM;
          end else if (!item.valve_open) begin
            phase_next        = vsis_pkg::PH_DONE;
            final_status_next = vsis_pkg::ST_OK;
          end else begin
            confirm_count_next = confirm_inc;
            if (confirm_out) begin
              phase_next        = vsis_pkg::PH_DONE;
              final_status_next = vsis_pkg::ST_VALVE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= vsis_pkg::PH_IDLE;
      final_status  <= vsis_pkg::ST_RUN;
      elapsed_count <= '0;
      hold_count    <= '0;
      confirm_count <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      final_status  <= final_status_next;
      elapsed_count <= elapsed_count_next;
      hold_count    <= hold_count_next;
      confirm_count <= confirm_count_next;
    end
  end

  // result register
  vsis_pkg::result_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.command         <= cmd;
      result.status          <= final_status_next;
      result.elapsed_seconds <= elapsed_count_next;
      result.held_seconds    <= hold_count_next;
    end
  end

  assign m_tdata = {3'b0, result.held_seconds, result.elapsed_seconds,
                    result.status, result.command};

endmodule

`default_nettype wire

@@ rtl/vsis_checker.sv @@
// ----------------------------------------------------------------------------
// vsis_checker
// port-level checks for the vacuum start interlock sequencer
// ----------------------------------------------------------------------------
`default_nettype none

`include "vacuum_start_interlock_sequencer_core_macros.svh"

module vsis_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [vsis_pkg::OUT_DATA_W-1:0]  m_tdata
);

  logic [vsis_pkg::CMD_BITS-1:0]    out_cmd;
  logic [vsis_pkg::STATUS_BITS-1:0] out_status;
  logic [vsis_pkg::TIME_BITS-1:0]   out_elapsed;
  logic [vsis_pkg::TIME_BITS-1:0]   out_held;

  assign out_cmd     = m_tdata[vsis_pkg::OUT_STATUS_LSB-1:vsis_pkg::OUT_CMD_LSB];
  assign out_status  = m_tdata[vsis_pkg::OUT_EL_LSB-1:vsis_pkg::OUT_STATUS_LSB];
  assign out_elapsed = m_tdata[vsis_pkg::OUT_HELD_LSB-1:vsis_pkg::OUT_EL_LSB];
  assign out_held    = m_tdata[vsis_pkg::OUT_HELD_LSB+vsis_pkg::TIME_BITS-1:
                               vsis_pkg::OUT_HELD_LSB];

  // a command is only issued while the run is still going
  `VSIS_ASSERT_NOW(a_cmd_running, rst, m_tvalid && out_cmd != vsis_pkg::CMD_NONE,
    out_status == vsis_pkg::ST_RUN, "command issued on a finished run")

  // a running result with no command and no elapsed time always has a cleared hold count
  `VSIS_ASSERT_NOW(a_start_clears, rst,
    m_tvalid && out_status == vsis_pkg::ST_RUN && out_cmd == vsis_pkg::CMD_NONE &&
    out_elapsed == '0,
    out_held == '0, "hold count without elapsed time")

  // nothing comes out right after reset
  `VSIS_ASSERT_NEXT(a_reset_empty, 1'b0, rst, !m_tvalid, "result valid after reset")

  // a stalled result holds
  `VSIS_ASSERT_NEXT(a_out_hold, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata), "result changed while stalled")

endmodule

bind vacuum_start_interlock_sequencer_core vsis_checker u_vsis_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// stream and register level test of the vacuum start interlock sequencer:
// polls and starts go in through the slave stream, every accepted word is
// run through a cycle-free copy of the run state, and each result word is
// compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PB = vsis_pkg::PRESSURE_BITS;
  localparam int TB = vsis_pkg::TIME_BITS;
  localparam int CB = vsis_pkg::CONFIRM_BITS;

  localparam int IDLE_PCT        = 26;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam logic [PB-1:0] PRESSURE_TOP = '1;

  typedef struct {
    logic          start;
    logic          comm_ok;
    logic [PB-1:0] pressure;
    logic          valve_open;
    logic          manual;
    logic          cancel;
  } poll_t;

  logic                                clk;
  logic                                rst      = 1'b1;
  logic                                s_tvalid = 1'b0;
  logic                                s_tready;
  // comm_ok, pressure[40], valve_open, manual_exhaust, cancel_pressed, pad[4]
  logic [vsis_pkg::IN_DATA_W-1:0]      s_tdata  = '0;
  // operation
  logic                                s_tuser  = 1'b0;
  logic                                m_tvalid;
  logic                                m_tready = 1'b0;
  // command[2], status[3], elapsed_seconds[16], held_seconds[16], pad[3]
  logic [vsis_pkg::OUT_DATA_W-1:0]     m_tdata;
  logic                                psel     = 1'b0;
  logic                                penable  = 1'b0;
  logic                                pwrite   = 1'b0;
  logic [vsis_pkg::CFG_ADDR_W-1:0]     paddr    = '0;
  logic [vsis_pkg::CFG_DATA_W-1:0]     pwdata   = '0;
  logic [vsis_pkg::CFG_DATA_W-1:0]     prdata;
  logic                                pready;

  // register copies
  logic [PB-1:0] cfg_start = vsis_pkg::START_PRESSURE_RST;
  logic [TB-1:0] cfg_max   = vsis_pkg::MAX_WAIT_RST;
  logic [TB-1:0] cfg_hold  = vsis_pkg::HOLD_RST;
  logic [CB-1:0] cfg_limit = vsis_pkg::CONFIRM_LIMIT_RST;

  // run state copy
  vsis_pkg::phase_t  run_phase   = vsis_pkg::PH_IDLE;
  logic [TB-1:0]     run_elapsed = '0;
  logic [TB-1:0]     run_hold    = '0;
  logic [CB-1:0]     run_confirm = '0;
  vsis_pkg::status_t run_status  = vsis_pkg::ST_RUN;

  vsis_pkg::result_t status_due[$];
  int                failures      = 0;
  int unsigned       cycle_count   = 0;
  logic              calm          = 1'b0;
  logic              sink_hold_req = 1'b0;

  vacuum_start_interlock_sequencer_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void close_run(input vsis_pkg::status_t st);
    run_status = st;
    run_phase  = vsis_pkg::PH_DONE;
  endfunction

  function automatic logic confirm_spent();
    logic [CB-1:0] lim;
    lim = (cfg_limit == '0) ? CB'(1) : cfg_limit;
    if (run_confirm != '1) run_confirm++;
    return run_confirm >= lim;
  endfunction

  function automatic vsis_pkg::result_t step_interlock(input poll_t w);
    vsis_pkg::result_t r;
    r.command = vsis_pkg::CMD_NONE;
    if (w.start) begin
      run_phase   = vsis_pkg::PH_WAIT;
      run_elapsed = '0;
      run_hold    = '0;
      run_confirm = '0;
      run_status  = vsis_pkg::ST_RUN;
    end else begin
      case (run_phase)
        vsis_pkg::PH_WAIT: begin
          if (run_elapsed != '1) run_elapsed++;
          if (w.cancel) begin
            close_run(vsis_pkg::ST_CANCEL);
          end else if (!w.comm_ok) begin
            close_run(vsis_pkg::ST_COMM);
          end else if (w.pressure <= cfg_start) begin
            if (!w.valve_open) begin
              close_run(vsis_pkg::ST_OK);
            end else begin
              if (run_hold != '1) run_hold++;
              if (run_hold >= cfg_hold) begin
                r.command   = vsis_pkg::CMD_SET_EXHAUST;
                run_confirm = '0;
                run_phase   = vsis_pkg::PH_EXH;
              end
            end
          end else begin
            if (run_hold != '0) run_hold--;
            // more than 10% over the start level, without the 11x product
            if (!w.valve_open && (w.pressure - cfg_start) > cfg_start / 10)
              close_run(vsis_pkg::ST_PRESS);
          end
          if (run_phase == vsis_pkg::PH_WAIT &&
              ((TB+1)'(run_elapsed) >= (TB+1)'(cfg_max) + cfg_hold ||
               (run_elapsed >= cfg_max && run_hold == '0)))
            close_run(vsis_pkg::ST_OVERTIME);
        end
        vsis_pkg::PH_EXH: begin
          if (w.cancel) begin
            close_run(vsis_pkg::ST_CANCEL);
          end else if (!w.comm_ok) begin
            close_run(vsis_pkg::ST_COMM);
          end else if (w.manual) begin
            r.command   = vsis_pkg::CMD_TOGGLE_VALVE;
            run_confirm = '0;
            run_phase   = vsis_pkg::PH_VALVE;
          end else if (confirm_spent()) begin
            close_run(vsis_pkg::ST_MODE_ERR);
          end
        end
        vsis_pkg::PH_VALVE: begin
          if (w.cancel) begin
            close_run(vsis_pkg::ST_CANCEL);
          end else if (!w.comm_ok) begin
            close_run(vsis_pkg::ST_COMM);
          end else if (!w.valve_open) begin
            close_run(vsis_pkg::ST_OK);
          end else if (confirm_spent()) begin
            close_run(vsis_pkg::ST_VALVE);
          end
        end
        default: ;
      endcase
    end
    r.status          = run_status;
    r.elapsed_seconds = run_elapsed;
    r.held_seconds    = run_hold;
    return r;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin
    vsis_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (status_due.size() == 0) begin
        $error("result word with no prediction waiting: %h", m_tdata);
        failures++;
      end else begin
        want = status_due.pop_front();
        if (m_tdata[vsis_pkg::OUT_CMD_LSB +: vsis_pkg::CMD_BITS] !== want.command) begin
          $error("command: expected %0d, got %0d", want.command,
                 m_tdata[vsis_pkg::OUT_CMD_LSB +: vsis_pkg::CMD_BITS]);
          failures++;
        end
        if (m_tdata[vsis_pkg::OUT_STATUS_LSB +: vsis_pkg::STATUS_BITS] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status,
                 m_tdata[vsis_pkg::OUT_STATUS_LSB +: vsis_pkg::STATUS_BITS]);
          failures++;
        end
        if (m_tdata[vsis_pkg::OUT_EL_LSB +: TB] !== want.elapsed_seconds) begin
          $error("elapsed_seconds: expected %0d, got %0d", want.elapsed_seconds,
                 m_tdata[vsis_pkg::OUT_EL_LSB +: TB]);
          failures++;
        end
        if (m_tdata[vsis_pkg::OUT_HELD_LSB +: TB] !== want.held_seconds) begin
          $error("held_seconds: expected %0d, got %0d", want.held_seconds,
                 m_tdata[vsis_pkg::OUT_HELD_LSB +: TB]);
          failures++;
        end
      end
    end
  end

  // result side: random backpressure, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // valid stays up after a word goes through; whatever comes next drops or reuses it
  task automatic send_word(input poll_t w);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.start;
    s_tdata  <= {4'b0000, w.cancel, w.manual, w.valve_open, w.pressure, w.comm_ok};
    do @(posedge clk); while (!s_tready);
    status_due.push_back(step_interlock(w));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (status_due.size() != 0);
  endtask

  task automatic write_reg(input vsis_pkg::reg_index_t idx,
                           input logic [vsis_pkg::CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      vsis_pkg::REG_START_PRESSURE: cfg_start = value[PB-1:0];
      vsis_pkg::REG_MAX_WAIT:       cfg_max   = value[TB-1:0];
      vsis_pkg::REG_HOLD:           cfg_hold  = value[TB-1:0];
      vsis_pkg::REG_CONFIRM_LIMIT:  cfg_limit = value[CB-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // unused upper bits carry junk, the block must drop them
  task automatic apply_setting(input logic [PB-1:0] sp,
                               input logic [TB-1:0] mw,
                               input logic [TB-1:0] hs,
                               input logic [CB-1:0] cl);
    write_reg(vsis_pkg::REG_START_PRESSURE, {24'($urandom), sp});
    write_reg(vsis_pkg::REG_MAX_WAIT, {$urandom(), 16'($urandom), mw});
    write_reg(vsis_pkg::REG_HOLD, {$urandom(), 16'($urandom), hs});
    write_reg(vsis_pkg::REG_CONFIRM_LIMIT, {$urandom(), 24'($urandom), cl});
  endtask

  function automatic poll_t plant_poll(input logic comm, input logic [PB-1:0] p,
                                       input logic vo, input logic me, input logic cn);
    poll_t w;
    w.start      = 1'b0;
    w.comm_ok    = comm;
    w.pressure   = p;
    w.valve_open = vo;
    w.manual     = me;
    w.cancel     = cn;
    return w;
  endfunction

  task automatic open_run();
    poll_t w;
    w = plant_poll(1'($urandom), {8'($urandom), $urandom()}, 1'($urandom),
                   1'($urandom), 1'($urandom));
    w.start = 1'b1;
    send_word(w);
  endtask

  function automatic logic [PB-1:0] pick_pressure();
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] p;
    r = {$urandom(), $urandom()};
    s = 64'(cfg_start);
    case ($urandom_range(9))
      0:       p = 0;
      1:       p = 64'(PRESSURE_TOP);
      2:       p = 64'(r[PB-1:0]);
      3, 4, 5: p = r % (s + 1);
      6:       p = s;
      7:       p = s + 1 + r % (s / 10 + 1);
      default: p = s + s / 10 + $urandom_range(2);
    endcase
    return (p > 64'(PRESSURE_TOP)) ? PRESSURE_TOP : p[PB-1:0];
  endfunction

  // plant behavior is weighted per phase: manual exhaust is likely in the exhaust phase, an open valve elsewhere
  function automatic poll_t shaped_poll();
    poll_t w;
    w.start    = ($urandom_range(99) < 2);
    w.comm_ok  = ($urandom_range(99) >= 3);
    w.cancel   = ($urandom_range(99) < 3);
    w.pressure = pick_pressure();
    case (run_phase)
      vsis_pkg::PH_EXH: begin
        w.manual     = ($urandom_range(99) < 60);
        w.valve_open = 1'($urandom);
      end
      vsis_pkg::PH_VALVE: begin
        w.valve_open = ($urandom_range(99) < 60);
        w.manual     = 1'($urandom);
      end
      default: begin
        w.valve_open = ($urandom_range(99) < 80);
        w.manual     = ($urandom_range(99) < 10);
      end
    endcase
    return w;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_idle_polls();
    send_word(plant_poll(1'b1, PRESSURE_TOP, 1'b1, 1'b1, 1'b1));
    send_word(plant_poll(1'b0, '0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_run_outcomes();
    open_run();
    send_word(plant_poll(1'b1, 40'd1000, 1'b0, 1'b0, 1'b0));
    // ignored once the run is over
    send_word(plant_poll(1'b0, 40'd5, 1'b1, 1'b1, 1'b1));
    // cancel wins over a comm fault
    open_run();
    send_word(plant_poll(1'b0, '0, 1'b0, 1'b0, 1'b1));
    open_run();
    send_word(plant_poll(1'b0, '0, 1'b0, 1'b0, 1'b0));
    // exactly 10% over is still fine, one more is not
    open_run();
    send_word(plant_poll(1'b1, 40'd1100, 1'b0, 1'b0, 1'b0));
    send_word(plant_poll(1'b1, 40'd1101, 1'b0, 1'b0, 1'b0));
    // restart in the middle of a run
    open_run();
    send_word(plant_poll(1'b1, PRESSURE_TOP, 1'b1, 1'b0, 1'b0));
    open_run();
  endtask

  task automatic test_exhaust_and_valve();
    wait_drained();
    // zero limit behaves as one; zero wait puts overtime on every poll with no hold
    apply_setting(vsis_pkg::START_PRESSURE_RST, '0, 16'd2, '0);
    open_run();
    send_word(plant_poll(1'b1, 40'd500, 1'b1, 1'b0, 1'b0));
    send_word(plant_poll(1'b1, 40'd7, 1'b1, 1'b0, 1'b0));
    send_word(plant_poll(1'b1, '0, 1'b1, 1'b0, 1'b0));
    open_run();
    send_word(plant_poll(1'b1, 40'd1000, 1'b1, 1'b0, 1'b0));
    send_word(plant_poll(1'b1, 40'd999, 1'b1, 1'b0, 1'b0));
    send_word(plant_poll(1'b1, 40'd3000, 1'b1, 1'b1, 1'b0));
    send_word(plant_poll(1'b1, '0, 1'b1, 1'b0, 1'b0));
    open_run();
    send_word(plant_poll(1'b1, 40'd1, 1'b1, 1'b0, 1'b0));
    send_word(plant_poll(1'b1, 40'd2, 1'b1, 1'b0, 1'b0));
    send_word(plant_poll(1'b1, 40'd2, 1'b1, 1'b1, 1'b0));
    send_word(plant_poll(1'b1, 40'd2, 1'b0, 1'b0, 1'b0));
    open_run();
    send_word(plant_poll(1'b1, 40'd1001, 1'b1, 1'b0, 1'b0));
  endtask

  task automatic test_zero_start_level();
    wait_drained();
    write_reg(vsis_pkg::REG_START_PRESSURE, '0);
    open_run();
    send_word(plant_poll(1'b1, 40'd1, 1'b0, 1'b0, 1'b0));
    open_run();
    send_word(plant_poll(1'b1, '0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_random_runs();
    int    sent;
    poll_t w;
    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      case (ph)
        0: apply_setting(vsis_pkg::START_PRESSURE_RST, vsis_pkg::MAX_WAIT_RST,
                         16'd3, 8'd2);
        1: apply_setting({8'($urandom), $urandom()}, 16'($urandom_range(30)),
                         16'($urandom_range(6)), 8'($urandom_range(1, 6)));
        2: apply_setting(PRESSURE_TOP, '1, 16'd1, '1);
        3: apply_setting('0, '0, '0, 8'd1);
        4: apply_setting(40'($urandom_range(1, 100000)), 16'd5, '1, 8'd3);
        default: apply_setting(vsis_pkg::START_PRESSURE_RST, vsis_pkg::MAX_WAIT_RST,
                               vsis_pkg::HOLD_RST, vsis_pkg::CONFIRM_LIMIT_RST);
      endcase
      calm = (ph == 0);
      sent = 0;
      while (sent < 230) begin
        // stall the result side while words keep coming
        if (ph == 1 && sent == 0) sink_hold_req = 1'b1;
        if (ph == 2 && sent == 115) wait_drained();
        w = shaped_poll();
        if ((run_phase == vsis_pkg::PH_IDLE || run_phase == vsis_pkg::PH_DONE) &&
            $urandom_range(99) >= 15)
          w.start = 1'b1;
        if (w.start ||
            (run_phase != vsis_pkg::PH_IDLE && run_phase != vsis_pkg::PH_DONE))
          sent++;
        send_word(w);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_idle_polls();
    test_run_outcomes();
    test_exhaust_and_valve();
    test_zero_start_level();
    test_random_runs();
    wait_drained();
    repeat (8) @(posedge clk);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/vsis_pkg.sv
rtl/vacuum_start_interlock_sequencer_core.sv
rtl/vsis_checker.sv
tb/tb.sv
